FILE: src/i2c_master_byte_sequencer_defines.svh
// Assertion helpers shared by the sequencer RTL.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define I2CMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/i2cms_pkg.sv
package i2cms_pkg;

    localparam int unsigned PHASE_W          = 16;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned KIND_W           = 3;
    localparam int unsigned BIT_CNT_W        = 4;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd16;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE  = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_ACK   = 3'd5,
        KIND_NACK  = 3'd6
    } kind_t;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_ST_HI   = 13'b0000000000010,
        ST_ST_LO   = 13'b0000000000100,
        ST_SP_LO   = 13'b0000000001000,
        ST_SP_CH   = 13'b0000000010000,
        ST_WR_BIT  = 13'b0000000100000,
        ST_WR_CLK  = 13'b0000001000000,
        ST_WR_REL  = 13'b0000010000000,
        ST_WR_ACK  = 13'b0000100000000,
        ST_RD_LO   = 13'b0001000000000,
        ST_RD_HI   = 13'b0010000000000,
        ST_AK_SET  = 13'b0100000000000,
        ST_AK_CLK  = 13'b1000000000000
    } step_t;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_bit;
    } res_t;

endpackage

FILE: src/i2cms_if.sv
interface i2cms_cmd_if;
    import i2cms_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              sda_in;

    modport source (output valid, output kind, output data, output sda_in, input ready);
    modport sink   (input valid, input kind, input data, input sda_in, output ready);
endinterface

interface i2cms_res_if;
    import i2cms_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              ack_bit;

    modport source (
        output valid, output scl, output sda_out, output sda_drive, output busy_res,
        output done_res, output read_byte, output ack_bit, input ready
    );
    modport sink (
        input valid, input scl, input sda_out, input sda_drive, input busy_res,
        input done_res, input read_byte, input ack_bit, output ready
    );
endinterface

interface i2cms_cfg_if;
    import i2cms_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/i2cms_seq.sv
`include "i2c_master_byte_sequencer_defines.svh"

module i2cms_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [i2cms_pkg::KIND_W-1:0]  kind,
    input  logic [i2cms_pkg::BYTE_W-1:0]  data,
    input  logic                          sda_in,
    input  logic [i2cms_pkg::PHASE_W-1:0] phase_ticks,
    output i2cms_pkg::res_t               res_next
);
    import i2cms_pkg::*;

    step_t                step_reg, step_next;
    logic [BIT_CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BIT_CNT_W-1:0] bit_count_inc;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [PHASE_W-1:0]   delay_reg, delay_next;
    logic [PHASE_W-1:0]   delay_reload;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 drive_reg, drive_next;
    logic                 ack_reg, ack_next;
    logic [BYTE_W-1:0]    read_reg, read_next;
    logic                 done;

    assign delay_reload  = (phase_ticks == '0) ? '0 : phase_ticks - PHASE_W'(1);
    assign bit_count_inc = bit_count_reg + BIT_CNT_W'(1);

    always_comb
    begin
        step_next      = step_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drive_next     = drive_reg;
        ack_next       = ack_reg;
        read_next      = read_reg;
        done           = 1'b0;

        if (fire)
        begin
            if (step_reg == ST_IDLE)
            begin
                case (kind_t'(kind))
                    KIND_START:
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        step_next  = ST_ST_HI;
                        delay_next = delay_reload;
                    end
                    KIND_STOP:
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b0;
                        step_next  = ST_SP_LO;
                        delay_next = delay_reload;
                    end
                    KIND_WRITE:
                    begin
                        drive_next     = 1'b1;
                        shift_next     = data;
                        bit_count_next = '0;
                        scl_next       = 1'b0;
                        sda_next       = data[BYTE_W-1];
                        step_next      = ST_WR_BIT;
                        delay_next     = delay_reload;
                    end
                    KIND_READ:
                    begin
                        drive_next     = 1'b0;
                        scl_next       = 1'b0;
                        shift_next     = '0;
                        bit_count_next = '0;
                        step_next      = ST_RD_LO;
                        delay_next     = delay_reload;
                    end
                    KIND_ACK, KIND_NACK:
                    begin
                        drive_next = 1'b1;
                        sda_next   = (kind_t'(kind) == KIND_NACK);
                        scl_next   = 1'b0;
                        step_next  = ST_AK_SET;
                        delay_next = delay_reload;
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                    end
                endcase
            end
            else if (delay_reg != '0)
            begin
                delay_next = delay_reg - PHASE_W'(1);
            end
            else
            begin
                case (step_reg)
                    ST_ST_HI:
                    begin
                        sda_next   = 1'b0;
                        step_next  = ST_ST_LO;
                        delay_next = delay_reload;
                    end
                    ST_ST_LO:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    ST_SP_LO:
                    begin
                        scl_next   = 1'b1;
                        step_next  = ST_SP_CH;
                        delay_next = delay_reload;
                    end
                    ST_SP_CH:
                    begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                    ST_WR_BIT:
                    begin
                        scl_next   = 1'b1;
                        step_next  = ST_WR_CLK;
                        delay_next = delay_reload;
                    end
                    ST_WR_CLK:
                    begin
                        scl_next       = 1'b0;
                        shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                        bit_count_next = bit_count_inc;
                        delay_next     = delay_reload;
                        if (bit_count_inc >= BITS_PER_BYTE)
                        begin
                            drive_next = 1'b0;
                            step_next  = ST_WR_REL;
                        end
                        else
                        begin
                            sda_next  = shift_reg[BYTE_W-2];
                            step_next = ST_WR_BIT;
                        end
                    end
                    ST_WR_REL:
                    begin
                        scl_next   = 1'b1;
                        step_next  = ST_WR_ACK;
                        delay_next = delay_reload;
                    end
                    ST_WR_ACK:
                    begin
                        ack_next = sda_in;
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    ST_RD_LO:
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                        scl_next   = 1'b1;
                        step_next  = ST_RD_HI;
                        delay_next = delay_reload;
                    end
                    ST_RD_HI:
                    begin
                        scl_next       = 1'b0;
                        bit_count_next = bit_count_inc;
                        if (bit_count_inc >= BITS_PER_BYTE)
                        begin
                            read_next = shift_reg;
                            done      = 1'b1;
                        end
                        else
                        begin
                            step_next  = ST_RD_LO;
                            delay_next = delay_reload;
                        end
                    end
                    ST_AK_SET:
                    begin
                        scl_next   = 1'b1;
                        step_next  = ST_AK_CLK;
                        delay_next = delay_reload;
                    end
                    ST_AK_CLK:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    default:
                    begin
                        step_next  = ST_IDLE;
                        delay_next = '0;
                    end
                endcase
                if (done)
                begin
                    step_next  = ST_IDLE;
                    delay_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b0;
            ack_reg       <= 1'b0;
            read_reg      <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drive_reg     <= drive_next;
            ack_reg       <= ack_next;
            read_reg      <= read_next;
        end
    end

    always_comb
    begin
        res_next.scl       = scl_next;
        res_next.sda_out   = sda_next;
        res_next.sda_drive = drive_next;
        res_next.busy_res  = (step_next != ST_IDLE);
        res_next.done_res  = done;
        res_next.read_byte = read_next;
        res_next.ack_bit   = ack_next;
    end

    `I2CMS_ASSERT(a_bit_count_range, bit_count_reg <= BITS_PER_BYTE, "bit count passed a byte")
    `I2CMS_ASSERT_NEXT(a_phase_hold, fire && step_reg != ST_IDLE && delay_reg != '0, step_reg == $past(step_reg), "step left before its phase ended")
    `I2CMS_ASSERT_NEXT(a_done_idle, fire && done, step_reg == ST_IDLE && !drive_reg == !$past(drive_next), "sequencer not idle after done")
    `I2CMS_ASSERT_NEXT(a_none_stays_idle, fire && step_reg == ST_IDLE && kind == KIND_NONE, step_reg == ST_IDLE, "idle left without a request")

endmodule

FILE: src/i2c_master_byte_sequencer.sv
// I2C master byte sequencer.
// The cmd channel carries one request per bus tick: a command code, a byte to send and the
// sampled SDA level. A command is taken only while the sequencer is idle; otherwise the code
// is ignored and the request only advances the current bus phase by one tick.
// The res channel returns one result per request: SCL, the SDA level and drive enable, busy,
// a one-tick done pulse, the last byte read and the last acknowledge bit.
// The cfg channel writes the number of ticks each bus phase is held; it is always ready and
// must only be written while the sequencer is idle.
// A request is held in an input register and its result then in an output register; one
// request is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result stays in the output register, one more request is
// held in the input register, and cmd.ready drops until the result is taken.
// Reset clears the valid flags of both registers, idles the sequencer with SCL and SDA high
// and SDA released, and loads a phase length of 16 ticks.
module i2c_master_byte_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    i2cms_cmd_if.sink   cmd,
    i2cms_res_if.source res,
    i2cms_cfg_if.sink   cfg
);
    import i2cms_pkg::*;

    logic               in_valid_reg;
    logic [KIND_W-1:0]  in_kind_reg;
    logic [BYTE_W-1:0]  in_data_reg;
    logic               in_sda_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res_next;
    logic [PHASE_W-1:0] phase_reg;
    logic               fire;

    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    i2cms_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .kind        (in_kind_reg),
        .data        (in_data_reg),
        .sda_in      (in_sda_reg),
        .phase_ticks (phase_reg),
        .res_next    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PHASE_TICKS_RESET;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                phase_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_kind_reg <= cmd.kind;
            in_data_reg <= cmd.data;
            in_sda_reg  <= cmd.sda_in;
        end
        if (fire)
        begin
            out_reg <= res_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.scl       = out_reg.scl;
    assign res.sda_out   = out_reg.sda_out;
    assign res.sda_drive = out_reg.sda_drive;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;
    assign res.read_byte = out_reg.read_byte;
    assign res.ack_bit   = out_reg.ack_bit;

endmodule
